[rtl/srcr_pkg.sv]
// Shared types and constants for the sparse row column-select remap block.
`default_nettype none

package srcr_pkg;

  // Field widths of the transfers
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned COL_W  = 31;
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned NCOL_W = 6;
  localparam int unsigned TOT_W  = 32;
  // Row buffer index width inside a sort key (row buffer holds at most 64 entries)
  localparam int unsigned IDX_W  = 6;

  // Input action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_ENTRY   = 2'd2,
    ACT_ROW_END = 2'd3
  } action_e;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MATCH = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_END   = 6'b100000
  } state_e;

  // Sort key: new column first, arrival index breaks ties (stable order)
  typedef struct packed {
    logic [NCOL_W-1:0] col;
    logic [IDX_W-1:0]  idx;
  } key_t;

  // One row buffer word
  typedef struct packed {
    logic [NCOL_W-1:0] new_col;
    logic [VAL_W-1:0]  value;
  } row_word_t;

  localparam int unsigned ROW_WORD_W = NCOL_W + VAL_W;

  // Request to the shared compare unit
  typedef struct packed {
    logic [COL_W-1:0] sel_col;
    logic [COL_W-1:0] item_col;
    key_t             cand;
    key_t             prev;
    logic             prev_v;
    key_t             best;
    logic             best_v;
  } cmp_req_t;

  // Answer of the shared compare unit
  typedef struct packed {
    logic col_eq;
    logic take;
  } cmp_rsp_t;

endpackage

`default_nettype wire

[rtl/srcr_in_if.sv]
// Input channel: valid/ready handshake with the input item fields.
`default_nettype none

interface srcr_in_if;
  import srcr_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [COL_W-1:0] col_id;
  logic [VAL_W-1:0] entry_value;

  modport source (output valid, action, col_id, entry_value, input ready);
  modport sink   (input valid, action, col_id, entry_value, output ready);
endinterface

`default_nettype wire

[rtl/srcr_out_if.sv]
// Output channel: valid/ready handshake with the result item fields.
`default_nettype none

interface srcr_out_if;
  import srcr_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_row_end;
  logic [NCOL_W-1:0] new_col;
  logic [VAL_W-1:0]  out_value;
  logic [TOT_W-1:0]  row_total;
  logic              overflow;
  logic              last;

  modport source (output valid, is_row_end, new_col, out_value, row_total, overflow, last,
                  input ready);
  modport sink   (input valid, is_row_end, new_col, out_value, row_total, overflow, last,
                  output ready);
endinterface

`default_nettype wire

[rtl/sparse_row_column_select_remap_top.sv]
// Top level: column-select remap of compressed-row nonzeros under one small sequencer.
//
// Column-select remap for compressed-row nonzeros. A nonzero walks the selection RAM
// one entry a cycle through the shared compare unit; every matching list position is
// written into the row buffer RAM, while it has room, with that position (low 6 bits) as
// its new column. End of row drains the buffer: with an in-order selection each entry is
// read from the RAM (fetch) and then loaded into the output register once it is free
// (emit); with an out-of-order selection each emitted entry first rescans the whole buffer
// for the next key in (new column, arrival) order. The row-end result with the running
// kept total follows the entries. Input is not ready while a nonzero or a row drain is in
// progress; results sit in an output register, so the block returns to idle once the last
// one is loaded. No clearing pass is needed after reset.
`default_nettype none

module sparse_row_column_select_remap_top #(
  parameter int unsigned MAX_SELECT      = 64,
  parameter int unsigned MAX_ROW_ENTRIES = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  srcr_in_if.sink  in_i,
  srcr_out_if.source out_o
);
  import srcr_pkg::*;

  localparam int unsigned SEL_CW = $clog2(MAX_SELECT + 1);
  localparam int unsigned SEL_AW = (MAX_SELECT > 1) ? $clog2(MAX_SELECT) : 1;
  localparam int unsigned ROW_CW = $clog2(MAX_ROW_ENTRIES + 1);
  localparam int unsigned ROW_AW = (MAX_ROW_ENTRIES > 1) ? $clog2(MAX_ROW_ENTRIES) : 1;

  // Control state
  state_e             state_q, state_d;
  logic [SEL_CW-1:0]  sel_cnt_q, sel_cnt_d;
  logic               sorted_q, sorted_d;
  logic [ROW_CW-1:0]  fill_q, fill_d;
  logic [TOT_W-1:0]   kept_q, kept_d;
  logic               ovf_q, ovf_d;
  logic [SEL_CW-1:0]  sel_ptr_q, sel_ptr_d;
  logic               sel_pend_q, sel_pend_d;
  logic [ROW_CW-1:0]  row_ptr_q, row_ptr_d;
  logic               row_pend_q, row_pend_d;
  logic [ROW_CW-1:0]  n_q, n_d;
  logic [ROW_CW-1:0]  emit_cnt_q, emit_cnt_d;
  logic               prev_v_q, prev_v_d;
  logic               best_v_q, best_v_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers
  logic [COL_W-1:0]   last_col_q, last_col_d;
  logic [COL_W-1:0]   item_col_q, item_col_d;
  logic [VAL_W-1:0]   item_val_q, item_val_d;
  logic [SEL_CW-1:0]  sel_pend_idx_q, sel_pend_idx_d;
  logic [ROW_AW-1:0]  row_pend_idx_q, row_pend_idx_d;
  logic [ROW_AW-1:0]  best_idx_q, best_idx_d;
  key_t               prev_q, prev_d;
  key_t               best_q, best_d;
  logic               out_end_q, out_end_d;
  logic [NCOL_W-1:0]  out_col_q, out_col_d;
  logic [VAL_W-1:0]   out_val_q, out_val_d;
  logic [TOT_W-1:0]   out_tot_q, out_tot_d;
  logic               out_ovf_q, out_ovf_d;
  logic               out_last_q, out_last_d;

  // Memory ports
  logic               sel_we;
  logic [COL_W-1:0]   sel_rdata;
  logic               row_we;
  row_word_t          row_wdata;
  logic [ROW_AW-1:0]  row_raddr;
  logic [ROW_WORD_W-1:0] row_rdata_raw;
  row_word_t          row_rdata;

  cmp_req_t           cmp_req;
  cmp_rsp_t           cmp_rsp;

  logic               load_out;
  logic               out_free;
  logic [ROW_CW-1:0]  emit_nxt;
  key_t               cand;

  // Selection table
  srcr_ram #(
    .WIDTH (COL_W),
    .DEPTH (MAX_SELECT)
  ) u_sel_ram (
    .clk_i   (clk_i),
    .we_i    (sel_we),
    .waddr_i (sel_cnt_q[SEL_AW-1:0]),
    .wdata_i (in_i.col_id),
    .raddr_i (sel_ptr_q[SEL_AW-1:0]),
    .rdata_o (sel_rdata)
  );

  // Row buffer
  srcr_ram #(
    .WIDTH (ROW_WORD_W),
    .DEPTH (MAX_ROW_ENTRIES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (fill_q[ROW_AW-1:0]),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata_raw)
  );

  assign row_rdata = row_word_t'(row_rdata_raw);

  // Shared compare unit
  assign cand = '{col: row_rdata.new_col, idx: IDX_W'(row_pend_idx_q)};

  always_comb begin
    cmp_req.sel_col  = sel_rdata;
    cmp_req.item_col = item_col_q;
    cmp_req.cand     = cand;
    cmp_req.prev     = prev_q;
    cmp_req.prev_v   = prev_v_q;
    cmp_req.best     = best_q;
    cmp_req.best_v   = best_v_q;
  end

  srcr_cmp u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign emit_nxt = emit_cnt_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d        = state_q;
    sel_cnt_d      = sel_cnt_q;
    sorted_d       = sorted_q;
    fill_d         = fill_q;
    kept_d         = kept_q;
    ovf_d          = ovf_q;
    sel_ptr_d      = sel_ptr_q;
    sel_pend_d     = sel_pend_q;
    row_ptr_d      = row_ptr_q;
    row_pend_d     = row_pend_q;
    n_d            = n_q;
    emit_cnt_d     = emit_cnt_q;
    prev_v_d       = prev_v_q;
    best_v_d       = best_v_q;
    last_col_d     = last_col_q;
    item_col_d     = item_col_q;
    item_val_d     = item_val_q;
    sel_pend_idx_d = sel_pend_idx_q;
    row_pend_idx_d = row_pend_idx_q;
    best_idx_d     = best_idx_q;
    prev_d         = prev_q;
    best_d         = best_q;
    sel_we         = 1'b0;
    row_we         = 1'b0;
    row_wdata      = '{new_col: NCOL_W'(sel_pend_idx_q), value: item_val_q};
    row_raddr      = row_ptr_q[ROW_AW-1:0];
    load_out       = 1'b0;
    out_end_d      = 1'b0;
    out_col_d      = '0;
    out_val_d      = '0;
    out_last_d     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          unique case (action_e'(in_i.action))
            ACT_CLEAR: begin
              sel_cnt_d = '0;
              sorted_d  = 1'b1;
              fill_d    = '0;
              kept_d    = '0;
              ovf_d     = 1'b0;
            end
            ACT_APPEND: begin
              if (sel_cnt_q == SEL_CW'(MAX_SELECT)) begin
                ovf_d = 1'b1;
              end else begin
                sel_we     = 1'b1;
                sel_cnt_d  = sel_cnt_q + 1'b1;
                last_col_d = in_i.col_id;
                if ((sel_cnt_q != '0) && (in_i.col_id < last_col_q)) begin
                  sorted_d = 1'b0;
                end
              end
            end
            ACT_ENTRY: begin
              item_col_d = in_i.col_id;
              item_val_d = in_i.entry_value;
              sel_ptr_d  = '0;
              sel_pend_d = 1'b0;
              state_d    = ST_MATCH;
            end
            ACT_ROW_END: begin
              n_d        = fill_q;
              emit_cnt_d = '0;
              prev_v_d   = 1'b0;
              best_v_d   = 1'b0;
              row_ptr_d  = '0;
              row_pend_d = 1'b0;
              best_idx_d = '0;
              if (fill_q == '0) begin
                state_d = ST_END;
              end else if (sorted_q) begin
                state_d = ST_FETCH;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      // Walk the selection table, one entry a cycle
      ST_MATCH: begin
        if (sel_ptr_q < sel_cnt_q) begin
          sel_ptr_d      = sel_ptr_q + 1'b1;
          sel_pend_d     = 1'b1;
          sel_pend_idx_d = sel_ptr_q;
        end else begin
          sel_pend_d = 1'b0;
          state_d    = ST_IDLE;
        end
        if (sel_pend_q && cmp_rsp.col_eq) begin
          if (fill_q == ROW_CW'(MAX_ROW_ENTRIES)) begin
            ovf_d = 1'b1;
          end else begin
            row_we = 1'b1;
            fill_d = fill_q + 1'b1;
            if (kept_q != '1) begin
              kept_d = kept_q + 1'b1;
            end
          end
        end
      end

      // Search the buffer for the next key in sort order
      ST_SCAN: begin
        row_raddr = row_ptr_q[ROW_AW-1:0];
        if (row_ptr_q < n_q) begin
          row_ptr_d      = row_ptr_q + 1'b1;
          row_pend_d     = 1'b1;
          row_pend_idx_d = row_ptr_q[ROW_AW-1:0];
        end else begin
          row_pend_d = 1'b0;
          state_d    = ST_FETCH;
        end
        if (row_pend_q && cmp_rsp.take) begin
          best_d     = cand;
          best_v_d   = 1'b1;
          best_idx_d = row_pend_idx_q;
        end
      end

      ST_FETCH: begin
        row_raddr = best_idx_q;
        state_d   = ST_EMIT;
      end

      // Hand the chosen entry to the output register
      ST_EMIT: begin
        row_raddr = best_idx_q;
        if (out_free) begin
          load_out   = 1'b1;
          out_col_d  = row_rdata.new_col;
          out_val_d  = row_rdata.value;
          prev_d     = '{col: row_rdata.new_col, idx: IDX_W'(best_idx_q)};
          prev_v_d   = 1'b1;
          emit_cnt_d = emit_nxt;
          if (emit_nxt == n_q) begin
            state_d = ST_END;
          end else if (sorted_q) begin
            best_idx_d = ROW_AW'(emit_nxt);
            state_d    = ST_FETCH;
          end else begin
            row_ptr_d  = '0;
            row_pend_d = 1'b0;
            best_v_d   = 1'b0;
            state_d    = ST_SCAN;
          end
        end
      end

      // Row-end result
      ST_END: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_end_d  = 1'b1;
          out_last_d = 1'b1;
          fill_d     = '0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_tot_d = kept_q;
  assign out_ovf_d = ovf_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_cnt_q   <= '0;
      sorted_q    <= 1'b1;
      fill_q      <= '0;
      kept_q      <= '0;
      ovf_q       <= 1'b0;
      sel_ptr_q   <= '0;
      sel_pend_q  <= 1'b0;
      row_ptr_q   <= '0;
      row_pend_q  <= 1'b0;
      n_q         <= '0;
      emit_cnt_q  <= '0;
      prev_v_q    <= 1'b0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_cnt_q   <= sel_cnt_d;
      sorted_q    <= sorted_d;
      fill_q      <= fill_d;
      kept_q      <= kept_d;
      ovf_q       <= ovf_d;
      sel_ptr_q   <= sel_ptr_d;
      sel_pend_q  <= sel_pend_d;
      row_ptr_q   <= row_ptr_d;
      row_pend_q  <= row_pend_d;
      n_q         <= n_d;
      emit_cnt_q  <= emit_cnt_d;
      prev_v_q    <= prev_v_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    last_col_q     <= last_col_d;
    item_col_q     <= item_col_d;
    item_val_q     <= item_val_d;
    sel_pend_idx_q <= sel_pend_idx_d;
    row_pend_idx_q <= row_pend_idx_d;
    best_idx_q     <= best_idx_d;
    prev_q         <= prev_d;
    best_q         <= best_d;
    if (load_out) begin
      out_end_q  <= out_end_d;
      out_col_q  <= out_col_d;
      out_val_q  <= out_val_d;
      out_tot_q  <= out_tot_d;
      out_ovf_q  <= out_ovf_d;
      out_last_q <= out_last_d;
    end
  end

  // Channel outputs
  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.is_row_end = out_end_q;
  assign out_o.new_col    = out_col_q;
  assign out_o.out_value  = out_val_q;
  assign out_o.row_total  = out_tot_q;
  assign out_o.overflow   = out_ovf_q;
  assign out_o.last       = out_last_q;
endmodule

`default_nettype wire

[rtl/srcr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

`default_nettype wire

[rtl/srcr_cmp.sv]
// Shared compare unit: column match for the selection scan, key ordering for the sort scan.
`default_nettype none

module srcr_cmp (
  input  srcr_pkg::cmp_req_t req_i,
  output srcr_pkg::cmp_rsp_t rsp_o
);
  import srcr_pkg::*;

  logic above_prev;
  logic below_best;

  always_comb begin
    // Candidate must follow the last emitted key and beat the best so far
    above_prev   = !req_i.prev_v || (req_i.cand > req_i.prev);
    below_best   = !req_i.best_v || (req_i.cand < req_i.best);
    rsp_o.col_eq = (req_i.sel_col == req_i.item_col);
    rsp_o.take   = above_prev && below_best;
  end
endmodule

`default_nettype wire

[sim/tb_sparse_row_column_select_remap_top.sv]
// Testbench for the sparse row column-select remap block: self-predicting checker.
`timescale 1ns / 1ps

module tb_sparse_row_column_select_remap_top;
  import srcr_pkg::*;

  localparam int unsigned MAX_SEL  = 64;
  localparam int unsigned MAX_ROW  = 32;
  localparam int unsigned N_ITEMS  = 480;

  // One result as seen on the output channel
  typedef struct packed {
    logic              is_row_end;
    logic [NCOL_W-1:0] new_col;
    logic [VAL_W-1:0]  out_value;
    logic [TOT_W-1:0]  row_total;
    logic              overflow;
    logic              last;
  } remap_result_t;

  logic clk_i;
  logic rst_ni;

  srcr_in_if  in_if ();
  srcr_out_if out_if ();

  sparse_row_column_select_remap_top #(
    .MAX_SELECT     (MAX_SEL),
    .MAX_ROW_ENTRIES(MAX_ROW)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predicted block state
  logic [COL_W-1:0]  sel_tab [MAX_SEL];
  int unsigned       sel_cnt;
  bit                sel_sorted;
  logic [NCOL_W-1:0] row_col [MAX_ROW];
  logic [VAL_W-1:0]  row_val [MAX_ROW];
  int unsigned       row_fill;
  logic [TOT_W-1:0]  kept_total;
  bit                sticky_ovf;

  remap_result_t pending_results[$];
  int unsigned   fail_count = 0;
  int unsigned   items_sent = 0;
  int unsigned   burst_left = 0;

  // Column list of the current session, used to aim nonzeros at matches
  logic [COL_W-1:0] sel_list[$];

  // Predict the results of one accepted transfer
  function automatic void remap_predict(action_e act, logic [COL_W-1:0] col,
                                        logic [VAL_W-1:0] val);
    remap_result_t     r;
    logic [NCOL_W-1:0] c;
    logic [VAL_W-1:0]  v;
    int                j;
    case (act)
      ACT_CLEAR: begin
        sel_cnt    = 0;
        sel_sorted = 1'b1;
        row_fill   = 0;
        kept_total = '0;
        sticky_ovf = 1'b0;
      end
      ACT_APPEND: begin
        if (sel_cnt >= MAX_SEL) begin
          sticky_ovf = 1'b1;
        end else begin
          if (sel_cnt > 0 && col < sel_tab[sel_cnt-1]) sel_sorted = 1'b0;
          sel_tab[sel_cnt] = col;
          sel_cnt++;
        end
      end
      ACT_ENTRY: begin
        for (int i = 0; i < sel_cnt; i++) begin
          if (sel_tab[i] == col) begin
            if (row_fill >= MAX_ROW) begin
              sticky_ovf = 1'b1;
            end else begin
              row_col[row_fill] = i[NCOL_W-1:0];
              row_val[row_fill] = val;
              row_fill++;
              if (kept_total != '1) kept_total++;
            end
          end
        end
      end
      default: begin
        // stable insertion sort by new column for an out-of-order list
        if (!sel_sorted) begin
          for (int i = 1; i < row_fill; i++) begin
            c = row_col[i];
            v = row_val[i];
            j = i;
            while (j > 0 && row_col[j-1] > c) begin
              row_col[j] = row_col[j-1];
              row_val[j] = row_val[j-1];
              j--;
            end
            row_col[j] = c;
            row_val[j] = v;
          end
        end
        for (int i = 0; i < row_fill; i++) begin
          r = '{is_row_end: 1'b0, new_col: row_col[i], out_value: row_val[i],
                row_total: kept_total, overflow: sticky_ovf, last: 1'b0};
          pending_results = {pending_results, r};
        end
        r = '{is_row_end: 1'b1, new_col: '0, out_value: '0,
              row_total: kept_total, overflow: sticky_ovf, last: 1'b1};
        pending_results = {pending_results, r};
        row_fill = 0;
      end
    endcase
  endfunction

  // Send one transfer; the sender runs in bursts with random gaps in between
  task automatic drive_transfer(action_e act, logic [COL_W-1:0] col,
                                logic [VAL_W-1:0] val);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.col_id      <= col;
    in_if.entry_value <= val;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    items_sent++;
    remap_predict(act, col, val);
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [COL_W-1:0] rand_col();
    return COL_W'($urandom);
  endfunction

  // Extremes, equal and descending appends, empty row, append inside a row
  task automatic test_basic_rows();
    drive_transfer(ACT_CLEAR, '0, '0);
    drive_transfer(ACT_ROW_END, '0, '0);
    drive_transfer(ACT_ENTRY, '0, '1);
    drive_transfer(ACT_APPEND, '0, '0);
    drive_transfer(ACT_APPEND, '1, '1);
    drive_transfer(ACT_APPEND, '1, '0);
    drive_transfer(ACT_ENTRY, '1, '1);
    drive_transfer(ACT_ENTRY, '0, '0);
    drive_transfer(ACT_ENTRY, 31'h2AAA_AAAA, rand_val());
    drive_transfer(ACT_ROW_END, rand_col(), rand_val());
    // descending append: list no longer in order, row gets sorted
    drive_transfer(ACT_APPEND, 31'd5, '0);
    drive_transfer(ACT_ENTRY, 31'd5, 64'h5555_5555_5555_5555);
    drive_transfer(ACT_ENTRY, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    drive_transfer(ACT_ENTRY, '1, rand_val());
    drive_transfer(ACT_ROW_END, '0, '0);
    // append during a row only affects later nonzeros
    drive_transfer(ACT_ENTRY, 31'd9, rand_val());
    drive_transfer(ACT_APPEND, 31'd9, '0);
    drive_transfer(ACT_ENTRY, 31'd9, rand_val());
    drive_transfer(ACT_ENTRY, 31'd5, rand_val());
    drive_transfer(ACT_ROW_END, '0, '0);
    drive_transfer(ACT_CLEAR, '1, '1);
    drive_transfer(ACT_ROW_END, '1, '1);
  endtask

  // Fill the list past its end; the top positions come out as new columns
  task automatic test_selection_full();
    drive_transfer(ACT_CLEAR, '0, '0);
    for (int i = 0; i < MAX_SEL + 2; i++) begin
      drive_transfer(ACT_APPEND, COL_W'(i / 2), rand_val());
    end
    drive_transfer(ACT_ENTRY, 31'd31, rand_val());
    drive_transfer(ACT_ENTRY, 31'd32, rand_val());
    drive_transfer(ACT_ENTRY, 31'd0, rand_val());
    drive_transfer(ACT_ROW_END, '0, '0);
  endtask

  // Repeated column in an out-of-order list overruns the row buffer
  task automatic test_row_buffer_full();
    logic [COL_W-1:0] rep_col;
    rep_col = COL_W'($urandom_range(1, 32'h7FFF_FFFE));
    drive_transfer(ACT_CLEAR, '0, '0);
    drive_transfer(ACT_APPEND, '1, '0);
    for (int i = 0; i < 19; i++) drive_transfer(ACT_APPEND, rep_col, '0);
    drive_transfer(ACT_ENTRY, rep_col, rand_val());
    drive_transfer(ACT_ENTRY, rep_col, rand_val());
    drive_transfer(ACT_ENTRY, '1, rand_val());
    drive_transfer(ACT_ROW_END, '0, '0);
    // flag stays set on the next row
    drive_transfer(ACT_ENTRY, rep_col, rand_val());
    drive_transfer(ACT_ROW_END, '0, '0);
  endtask

  // Sessions of clear, list load and rows with random content and some noise
  task automatic test_random_sessions();
    int unsigned      n_sel;
    int unsigned      n_rows;
    int unsigned      n_nz;
    bit               in_order;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] pool[4];
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(0, 7) != 0) begin
        drive_transfer(ACT_CLEAR, rand_col(), rand_val());
        sel_list.delete();
      end
      foreach (pool[k]) pool[k] = rand_col();
      case ($urandom_range(0, 19))
        0:       n_sel = 0;
        1:       n_sel = $urandom_range(40, 70);
        default: n_sel = $urandom_range(1, 10);
      endcase
      in_order = $urandom_range(0, 1);
      col = COL_W'($urandom_range(0, 32'h7FFF_FF00));
      for (int i = 0; i < n_sel; i++) begin
        if (in_order) begin
          col = col + COL_W'($urandom_range(0, 2));
        end else begin
          col = ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, 3)] : rand_col();
        end
        drive_transfer(ACT_APPEND, col, rand_val());
        sel_list = {sel_list, col};
      end
      n_rows = $urandom_range(1, 4);
      for (int r = 0; r < n_rows; r++) begin
        n_nz = $urandom_range(0, 6);
        for (int e = 0; e < n_nz; e++) begin
          if ($urandom_range(0, 9) == 0) begin
            col = rand_col();
            drive_transfer(ACT_APPEND, col, rand_val());
            sel_list = {sel_list, col};
          end
          if (sel_list.size() > 0 && $urandom_range(0, 4) != 0) begin
            col = sel_list[$urandom_range(0, sel_list.size() - 1)];
          end else begin
            col = rand_col();
          end
          drive_transfer(ACT_ENTRY, col, rand_val());
        end
        drive_transfer(ACT_ROW_END, rand_col(), rand_val());
      end
    end
  endtask

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      fail_count++;
    end
  endfunction

  // Check every result transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    remap_result_t seen_r;
    remap_result_t want_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_r = '{is_row_end: out_if.is_row_end, new_col: out_if.new_col,
                 out_value: out_if.out_value, row_total: out_if.row_total,
                 overflow: out_if.overflow, last: out_if.last};
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: 0x%0h", seen_r);
        fail_count++;
      end else begin
        want_r = pending_results.pop_front();
        cmp_field("is_row_end", want_r.is_row_end, seen_r.is_row_end);
        cmp_field("new_col", want_r.new_col, seen_r.new_col);
        cmp_field("out_value", want_r.out_value, seen_r.out_value);
        cmp_field("row_total", want_r.row_total, seen_r.row_total);
        cmp_field("overflow", want_r.overflow, seen_r.overflow);
        cmp_field("last", want_r.last, seen_r.last);
      end
    end
  end

  // Receiver stalls follow a rotating pattern that is redrawn now and then
  logic [15:0] rx_pat = '1;
  int unsigned rx_pat_left = 0;

  always @(posedge clk_i) begin
    if (rx_pat_left == 0) begin
      rx_pat_left = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0:       rx_pat = '1;
        1:       rx_pat = 16'($urandom);
        2:       rx_pat = 16'($urandom | $urandom);
        default: rx_pat = 16'($urandom & $urandom);
      endcase
    end
    rx_pat_left--;
    rx_pat = {rx_pat[14:0], rx_pat[15]};
    out_if.ready <= rx_pat[0];
  end

  initial begin
    rst_ni             = 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_CLEAR;
    in_if.col_id      <= '0;
    in_if.entry_value <= '0;
    sel_cnt            = 0;
    sel_sorted         = 1'b1;
    row_fill           = 0;
    kept_total         = '0;
    sticky_ovf         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_rows();
    test_selection_full();
    test_row_buffer_full();
    test_random_sessions();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("sparse_row_column_select_remap_top: match");
    end else begin
      $display("sparse_row_column_select_remap_top: mismatch");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #200ms;
    $display("sparse_row_column_select_remap_top: mismatch");
    $finish;
  end

endmodule
